### rtl/l2vn_pkg.sv
// package for the l2 vector normalizer: widths, payload structs, fsm codes
// used by l2vn_sqrt, l2vn_div and l2_vector_normalizer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package l2vn_pkg;

  localparam int MaxLen   = 32;
  localparam int IdxW     = $clog2(MaxLen);
  localparam int CntW     = $clog2(MaxLen + 1);
  localparam int ElemW    = 16;
  localparam int SqW      = 2 * ElemW - 1;
  localparam int SumW     = 36;
  localparam int FracExt  = 16;
  localparam int RadW     = SumW + FracExt;
  localparam int RootW    = RadW / 2;
  localparam int QuotW    = 16;
  // dividend is (mag << 23) + root, divisor is 2 * root
  localparam int NumShift = 23;
  localparam int DvdW     = ElemW + NumShift;
  localparam int DsrW     = RootW + 1;
  localparam int SqrtCntW = $clog2(RootW + 1);
  localparam int DivCntW  = $clog2(QuotW + 1);
  localparam logic [QuotW-1:0] UnitMax = QuotW'(16384);

  typedef struct packed {
    logic signed [ElemW-1:0] element;
    logic                    last_in;
  } in_req_t;

  typedef struct packed {
    logic signed [ElemW-1:0] unit_element;
    logic                    last_out;
    logic                    zero_norm;
  } out_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_status_t;

  typedef enum logic [4:0] {
    S_COLLECT = 5'b00001,
    S_ROOT    = 5'b00010,
    S_READ    = 5'b00100,
    S_LOAD    = 5'b01000,
    S_DIV     = 5'b10000
  } state_e;

endpackage

`default_nettype wire

### rtl/l2vn_sqrt.sv
// iterative integer square root, two radicand bits per cycle
// depends on l2vn_pkg
`timescale 1ns / 1ps
`default_nettype none

module l2vn_sqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [l2vn_pkg::RadW-1:0]    radicand_i,
  output logic      [l2vn_pkg::RootW-1:0]   root_o,
  output l2vn_pkg::iter_status_t            status_o
);

  logic [l2vn_pkg::RadW-1:0]     rad_q, rad_d;
  logic [l2vn_pkg::RootW:0]      rem_q, rem_d;
  logic [l2vn_pkg::RootW-1:0]    root_q, root_d;
  logic [l2vn_pkg::SqrtCntW-1:0] cnt_q, cnt_d;
  l2vn_pkg::iter_status_t        st_q, st_d;

  logic [l2vn_pkg::RootW+2:0] rem_sh;
  logic [l2vn_pkg::RootW+2:0] trial;
  logic [l2vn_pkg::RootW+2:0] diff;

  always_comb begin
    rem_sh = {rem_q, rad_q[l2vn_pkg::RadW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = rem_sh - trial;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    st_d   = st_q;
    if (start_i) begin
      rad_d     = radicand_i;
      rem_d     = '0;
      root_d    = '0;
      cnt_d     = l2vn_pkg::SqrtCntW'(l2vn_pkg::RootW);
      st_d.busy = 1'b1;
      st_d.done = 1'b0;
    end else if (st_q.busy) begin
      rad_d = {rad_q[l2vn_pkg::RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = diff[l2vn_pkg::RootW:0];
        root_d = {root_q[l2vn_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[l2vn_pkg::RootW:0];
        root_d = {root_q[l2vn_pkg::RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == l2vn_pkg::SqrtCntW'(1)) begin
        st_d.busy = 1'b0;
        st_d.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      st_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o   = root_q;
  assign status_o = st_q;

endmodule

`default_nettype wire

### rtl/l2vn_div.sv
// restoring divider, one quotient bit per cycle, saturates on overflow
// depends on l2vn_pkg
`timescale 1ns / 1ps
`default_nettype none

module l2vn_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [l2vn_pkg::DvdW-1:0]   dividend_i,
  input  wire logic [l2vn_pkg::DsrW-1:0]   divisor_i,
  output logic      [l2vn_pkg::QuotW-1:0]  quotient_o,
  output l2vn_pkg::iter_status_t           status_o
);

  localparam int HiW = l2vn_pkg::DvdW - l2vn_pkg::QuotW;

  logic [l2vn_pkg::DsrW-1:0]    rem_q, rem_d;
  logic [l2vn_pkg::DsrW-1:0]    dsr_q, dsr_d;
  logic [l2vn_pkg::QuotW-1:0]   low_q, low_d;
  logic [l2vn_pkg::QuotW-1:0]   quo_q, quo_d;
  logic                         ovf_q, ovf_d;
  logic [l2vn_pkg::DivCntW-1:0] cnt_q, cnt_d;
  l2vn_pkg::iter_status_t       st_q, st_d;

  logic [l2vn_pkg::DsrW:0] trial;
  logic [l2vn_pkg::DsrW:0] diff;
  logic [l2vn_pkg::DsrW:0] hi_ext;

  always_comb begin
    trial  = {rem_q, low_q[l2vn_pkg::QuotW-1]};
    diff   = trial - {1'b0, dsr_q};
    hi_ext = (l2vn_pkg::DsrW + 1)'(dividend_i[l2vn_pkg::DvdW-1 -: HiW]);
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    low_d  = low_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    st_d   = st_q;
    if (start_i) begin
      rem_d     = hi_ext[l2vn_pkg::DsrW-1:0];
      dsr_d     = divisor_i;
      low_d     = dividend_i[l2vn_pkg::QuotW-1:0];
      quo_d     = '0;
      // quotient would not fit in QuotW bits
      ovf_d     = hi_ext >= {1'b0, divisor_i};
      cnt_d     = l2vn_pkg::DivCntW'(l2vn_pkg::QuotW);
      st_d.busy = 1'b1;
      st_d.done = 1'b0;
    end else if (st_q.busy) begin
      low_d = {low_q[l2vn_pkg::QuotW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[l2vn_pkg::DsrW-1:0];
        quo_d = {quo_q[l2vn_pkg::QuotW-2:0], 1'b1};
      end else begin
        rem_d = trial[l2vn_pkg::DsrW-1:0];
        quo_d = {quo_q[l2vn_pkg::QuotW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == l2vn_pkg::DivCntW'(1)) begin
        st_d.busy = 1'b0;
        st_d.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      st_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    low_q <= low_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign quotient_o = ovf_q ? '1 : quo_q;
  assign status_o   = st_q;

endmodule

`default_nettype wire

### rtl/l2_vector_normalizer.sv
// l2 vector normalizer top level: element memory, running square sum, control
// depends on l2vn_pkg, l2vn_sqrt, l2vn_div
//
// usage:
//   input channel (in_valid_i/in_ready_o/in_req_i) takes one signed q3.12
//   element per request; last_in closes the vector. up to 32 elements are
//   kept in an on-chip memory, later ones are dropped but last_in still ends
//   the vector. while collecting, a request is taken every cycle.
//   after the last request the square root unit finds the norm (one root bit
//   per cycle) and the sequencer takes the root; then each stored element
//   takes a memory read, a divider load, the divider run and the fill of the
//   output register, and the next element starts only after that fill.
//   output channel (out_valid_o/out_ready_i/out_req_o) gives q1.14 results
//   in arrival order, last_out on the final one, zero_norm on all of them
//   when the sum of squares was zero (results are then zero).
//   the input is closed from the last request until the final result is in
//   the output register; a stalled receiver holds the sequencer at the
//   finished divider. reset empties the vector and the output register,
//   no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module l2_vector_normalizer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire l2vn_pkg::in_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output l2vn_pkg::out_req_t     out_req_o
);

  l2vn_pkg::state_e state_q, state_d;

  logic [l2vn_pkg::CntW-1:0]    count_q, count_d;
  logic [l2vn_pkg::SumW-1:0]    sum_q, sum_d;
  logic                         zero_q, zero_d;
  logic [l2vn_pkg::RootW-1:0]   root_q, root_d;
  logic [l2vn_pkg::IdxW-1:0]    idx_q, idx_d;
  logic                         neg_q, neg_d;
  logic                         out_valid_q, out_valid_d;
  l2vn_pkg::out_req_t           out_q, out_d;

  logic [l2vn_pkg::ElemW-1:0]   mem_q [l2vn_pkg::MaxLen];
  logic [l2vn_pkg::ElemW-1:0]   rd_data_q;
  logic                         mem_we;

  logic                         in_fire;
  logic                         has_room;
  logic signed [2*l2vn_pkg::ElemW-1:0] prod;
  logic [l2vn_pkg::SqW-1:0]     sq;
  logic [l2vn_pkg::SumW:0]      sum_add;
  logic [l2vn_pkg::SumW-1:0]    sum_next;

  logic                         sqrt_start;
  logic [l2vn_pkg::RootW-1:0]   sqrt_root;
  l2vn_pkg::iter_status_t       sqrt_st;

  logic                         div_start;
  logic [l2vn_pkg::ElemW-1:0]   mag;
  logic [l2vn_pkg::DvdW-1:0]    dividend;
  logic [l2vn_pkg::DsrW-1:0]    divisor;
  logic [l2vn_pkg::QuotW-1:0]   quot;
  logic [l2vn_pkg::QuotW-1:0]   quot_clamped;
  l2vn_pkg::iter_status_t       div_st;
  logic                         out_free;
  logic                         is_final;

  assign in_ready_o = (state_q == l2vn_pkg::S_COLLECT);
  assign in_fire    = in_valid_i & in_ready_o;
  assign has_room   = count_q < l2vn_pkg::CntW'(l2vn_pkg::MaxLen);

  // square of the element, saturating accumulate
  assign prod     = in_req_i.element * in_req_i.element;
  assign sq       = prod[l2vn_pkg::SqW-1:0];
  assign sum_add  = {1'b0, sum_q} + (l2vn_pkg::SumW + 1)'(sq);
  assign sum_next = !has_room ? sum_q :
                    (sum_add[l2vn_pkg::SumW] ? '1 : sum_add[l2vn_pkg::SumW-1:0]);

  assign mem_we     = in_fire & has_room;
  assign sqrt_start = in_fire & in_req_i.last_in;

  // divider operands from the element just read
  assign mag      = rd_data_q[l2vn_pkg::ElemW-1] ? (-rd_data_q) : rd_data_q;
  assign dividend = {mag, {l2vn_pkg::NumShift{1'b0}}} + l2vn_pkg::DvdW'(root_q);
  assign divisor  = {root_q, 1'b0};
  assign div_start = (state_q == l2vn_pkg::S_LOAD);

  assign quot_clamped = (quot > l2vn_pkg::UnitMax) ? l2vn_pkg::UnitMax : quot;
  assign out_free     = !out_valid_q || out_ready_i;
  assign is_final     = (({1'b0, idx_q} + 1'b1) == count_q);

  l2vn_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({sum_next, {l2vn_pkg::FracExt{1'b0}}}),
    .root_o     (sqrt_root),
    .status_o   (sqrt_st)
  );

  l2vn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quot),
    .status_o   (div_st)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    zero_d      = zero_q;
    root_d      = root_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      l2vn_pkg::S_COLLECT: begin
        if (in_fire) begin
          sum_d = sum_next;
          if (has_room) begin
            count_d = count_q + 1'b1;
          end
          if (in_req_i.last_in) begin
            zero_d  = (sum_next == '0);
            state_d = l2vn_pkg::S_ROOT;
          end
        end
      end
      l2vn_pkg::S_ROOT: begin
        if (sqrt_st.done) begin
          root_d  = sqrt_root;
          idx_d   = '0;
          state_d = l2vn_pkg::S_READ;
        end
      end
      l2vn_pkg::S_READ: begin
        state_d = l2vn_pkg::S_LOAD;
      end
      l2vn_pkg::S_LOAD: begin
        neg_d   = rd_data_q[l2vn_pkg::ElemW-1];
        state_d = l2vn_pkg::S_DIV;
      end
      l2vn_pkg::S_DIV: begin
        if (div_st.done && out_free) begin
          out_valid_d        = 1'b1;
          out_d.last_out     = is_final;
          out_d.zero_norm    = zero_q;
          if (zero_q) begin
            out_d.unit_element = '0;
          end else if (neg_q) begin
            out_d.unit_element = -quot_clamped;
          end else begin
            out_d.unit_element = quot_clamped;
          end
          if (is_final) begin
            count_d = '0;
            sum_d   = '0;
            state_d = l2vn_pkg::S_COLLECT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = l2vn_pkg::S_READ;
          end
        end
      end
      default: begin
        state_d = l2vn_pkg::S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= l2vn_pkg::S_COLLECT;
      count_q     <= '0;
      sum_q       <= '0;
      zero_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      zero_q      <= zero_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

  // element memory, one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[l2vn_pkg::IdxW-1:0]] <= in_req_i.element;
    end
    rd_data_q <= mem_q[idx_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire

### tb/tb_l2_vector_normalizer.sv
// testbench for l2_vector_normalizer: drives vectors over valid/ready and
// checks every normalized result against a predictor; depends on l2vn_pkg
`timescale 1ns / 1ps

module tb_l2_vector_normalizer;
  import l2vn_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_ready_i;
  out_req_t out_req_o;

  l2_vector_normalizer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  // predictor state: the vector being collected
  logic signed [ElemW-1:0] vec_elems [MaxLen];
  int                      vec_len;
  longint unsigned         vec_sum_sq;

  out_req_t unit_q [$];
  out_req_t want;
  int       errors;
  int       sent_count;
  bit       no_idle;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // digit by digit integer square root
  function automatic longint unsigned int_sqrt(input longint unsigned radicand);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = radicand;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // element * 2^22 / norm, rounded half away from zero, clamped to q1.14 unity
  function automatic logic signed [ElemW-1:0] scale_by_norm(
    input logic signed [ElemW-1:0] value,
    input longint unsigned         norm
  );
    longint unsigned mag;
    longint unsigned quo;
    mag = (value < 0) ? longint'(-int'(value)) : longint'(value);
    quo = ((mag << 23) + norm) / (2 * norm);
    if (quo > 16384) quo = 16384;
    return (value < 0) ? -ElemW'(quo) : ElemW'(quo);
  endfunction

  // fold one accepted request into the vector; on last, queue its results
  task automatic absorb_element(input logic signed [ElemW-1:0] value, input logic last);
    longint unsigned norm;
    longint unsigned sq;
    bit              is_zero;
    out_req_t        res;
    if (vec_len < MaxLen) begin
      sq = longint'(int'(value) * int'(value));
      vec_elems[vec_len] = value;
      vec_len++;
      vec_sum_sq += sq;
      if (vec_sum_sq > 64'hF_FFFF_FFFF) vec_sum_sq = 64'hF_FFFF_FFFF;
    end
    if (last) begin
      is_zero = (vec_sum_sq == 0);
      norm    = is_zero ? 0 : int_sqrt(vec_sum_sq << 16);
      for (int i = 0; i < vec_len; i++) begin
        res.unit_element = is_zero ? '0 : scale_by_norm(vec_elems[i], norm);
        res.last_out     = (i == vec_len - 1);
        res.zero_norm    = is_zero;
        unit_q = {unit_q, res};
      end
      vec_len    = 0;
      vec_sum_sq = 0;
    end
  endtask

  task automatic send_element(input logic signed [ElemW-1:0] value, input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{element: value, last_in: last};
    do @(posedge clk_i); while (!in_ready_o);
    absorb_element(value, last);
    sent_count++;
  endtask

  // hold the sender off until every queued result has been taken
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (unit_q.size() != 0);
  endtask

  function automatic logic signed [ElemW-1:0] rand_element(input int mode);
    case (mode)
      0:       return ElemW'($urandom_range(0, 65535));
      1:       return ElemW'(int'($urandom_range(0, 16)) - 8);
      2:       return '0;
      default: return ElemW'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  task automatic test_extremes();
    send_element(16'sh7FFF, 1'b1);
    send_element(16'sh8000, 1'b1);
    send_element(16'sh0001, 1'b1);
    send_element(16'shFFFF, 1'b1);
  endtask

  task automatic test_zero_length();
    send_element(16'sh0000, 1'b0);
    send_element(16'sh0000, 1'b0);
    send_element(16'sh0000, 1'b1);
    send_element(16'sh0000, 1'b1);
  endtask

  task automatic test_mixed_signs();
    send_element(16'sh7FFF, 1'b0);
    send_element(16'sh8000, 1'b0);
    send_element(16'sh0001, 1'b0);
    send_element(16'shFFFF, 1'b0);
    send_element(16'sh5555, 1'b0);
    send_element(16'shAAAA, 1'b1);
    // one large and one tiny component, the tiny one rounds up to 1
    send_element(16'sh7000, 1'b0);
    send_element(16'sh0001, 1'b1);
  endtask

  task automatic test_buffer_full();
    // exactly full, last on the final stored element
    for (int i = 0; i < MaxLen; i++) send_element(rand_element(0), i == MaxLen - 1);
    // overfull: the trailing components and the closing one are dropped
    for (int i = 0; i < MaxLen + 2; i++) send_element(rand_element(3), i == MaxLen + 1);
  endtask

  task automatic test_random_vectors(input int n_items);
    int stop_at;
    int len;
    int mode;
    int r;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 92) len = $urandom_range(9, 31);
      else len = $urandom_range(32, 38);
      r = $urandom_range(0, 99);
      if (r < 55) mode = 0;
      else if (r < 75) mode = 1;
      else if (r < 82) mode = 2;
      else mode = 3;
      for (int i = 0; i < len; i++) send_element(rand_element(mode), i == len - 1);
    end
  endtask

  task automatic test_drain_pause();
    send_element(rand_element(0), 1'b0);
    send_element(rand_element(0), 1'b1);
    wait_drained();
    send_element(rand_element(1), 1'b0);
    send_element(rand_element(0), 1'b0);
    send_element(rand_element(0), 1'b1);
  endtask

  // receiver: random stalls, with bursts of steady ready
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 20)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (unit_q.size() == 0) begin
        $error("unexpected request: unit_element %0d", out_req_o.unit_element);
        errors++;
      end else begin
        want = unit_q.pop_front();
        if (out_req_o.unit_element !== want.unit_element) begin
          $error("unit_element expected %0d actual %0d", want.unit_element,
                 out_req_o.unit_element);
          errors++;
        end
        if (out_req_o.last_out !== want.last_out) begin
          $error("last_out expected %0b actual %0b", want.last_out, out_req_o.last_out);
          errors++;
        end
        if (out_req_o.zero_norm !== want.zero_norm) begin
          $error("zero_norm expected %0b actual %0b", want.zero_norm, out_req_o.zero_norm);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    errors     = 0;
    sent_count = 0;
    no_idle    = 1'b0;
    vec_len    = 0;
    vec_sum_sq = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_zero_length();
    test_mixed_signs();
    test_drain_pause();
    no_idle = 1'b1;
    test_buffer_full();
    no_idle = 1'b0;
    test_random_vectors(70);
    wait_drained();
    no_idle = 1'b1;
    test_random_vectors(25);
    no_idle = 1'b0;
    test_random_vectors(45);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
